// ===== rtl/dfpid_pkg.sv =====
// Shared types, widths, register map and reset values of the dual-form PID controller.
package dfpid_pkg;

    // Sample and gain format.
    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 8;

    // Field widths fixed by the register map and the result channel.
    localparam int GAIN_W  = 16;
    localparam int INTEG_W = 24;
    localparam int DRIVE_W = 16;
    localparam int TOTAL_W = 32;

    // Derived datapath widths.
    localparam int ERR_W   = SAMPLE_WIDTH + 1;
    localparam int DIFF1_W = ERR_W + 1;
    localparam int DIFF2_W = ERR_W + 2;
    localparam int OPB_W   = (INTEG_W > ERR_W) ? INTEG_W : ERR_W;
    localparam int SUM_W   = OPB_W + 1;
    localparam int PROD_A_W = GAIN_W + DIFF1_W;
    localparam int PROD_B_W = GAIN_W + OPB_W;
    localparam int PROD_C_W = GAIN_W + DIFF2_W;
    localparam int PROD_MAX = (PROD_B_W > PROD_C_W) ? PROD_B_W : PROD_C_W;
    localparam int ACC_W    = ((PROD_MAX > TOTAL_W) ? PROD_MAX : TOTAL_W) + 2;
    localparam int V_W      = ACC_W - GAIN_FRAC_BITS;

    // Configuration port.
    localparam int NUM_REGS = 8;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
    localparam int IDX_W    = ADDR_W - 2;

    typedef enum logic [IDX_W-1:0] {
        REG_FORM_SELECT    = 3'd0,
        REG_GAIN_P         = 3'd1,
        REG_GAIN_I         = 3'd2,
        REG_GAIN_D         = 3'd3,
        REG_INTEGRAL_UPPER = 3'd4,
        REG_INTEGRAL_LOWER = 3'd5,
        REG_DRIVE_UPPER    = 3'd6,
        REG_DRIVE_LOWER    = 3'd7
    } reg_index_t;

    localparam logic FORM_POSITIONAL  = 1'b0;
    localparam logic FORM_INCREMENTAL = 1'b1;

    localparam logic signed [INTEG_W-1:0] INTEGRAL_UPPER_RST = 24'sd200;
    localparam logic signed [INTEG_W-1:0] INTEGRAL_LOWER_RST = -24'sd200;
    localparam logic signed [DRIVE_W-1:0] DRIVE_UPPER_RST    = 16'sd3000;
    localparam logic signed [DRIVE_W-1:0] DRIVE_LOWER_RST    = -16'sd3000;

    typedef struct packed {
        logic                      form_select;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [INTEG_W-1:0] integral_upper;
        logic signed [INTEG_W-1:0] integral_lower;
        logic signed [DRIVE_W-1:0] drive_upper;
        logic signed [DRIVE_W-1:0] drive_lower;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   last_error;
        logic signed [ERR_W-1:0]   older_error;
        logic signed [INTEG_W-1:0] integral;
        logic signed [TOTAL_W-1:0] total;
    } pid_state_t;

endpackage

// ===== rtl/dfpid_regs.sv =====
// Configuration register bank of the dual-form PID controller behind an APB-style port.
module dfpid_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfpid_pkg::ADDR_W-1:0]  paddr,
    input  logic [dfpid_pkg::DATA_W-1:0]  pwdata,
    output logic [dfpid_pkg::DATA_W-1:0]  prdata,
    output dfpid_pkg::cfg_t               cfg
);

    dfpid_pkg::cfg_t        cfg_reg;
    dfpid_pkg::reg_index_t  index;
    logic                   wr_en;

    assign index = dfpid_pkg::reg_index_t'(paddr[dfpid_pkg::ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.form_select    <= dfpid_pkg::FORM_POSITIONAL;
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_upper <= dfpid_pkg::INTEGRAL_UPPER_RST;
            cfg_reg.integral_lower <= dfpid_pkg::INTEGRAL_LOWER_RST;
            cfg_reg.drive_upper    <= dfpid_pkg::DRIVE_UPPER_RST;
            cfg_reg.drive_lower    <= dfpid_pkg::DRIVE_LOWER_RST;
        end else if (wr_en) begin
            case (index)
                dfpid_pkg::REG_FORM_SELECT: begin
                    cfg_reg.form_select <= pwdata[0];
                end
                dfpid_pkg::REG_GAIN_P: begin
                    cfg_reg.gain_p <= pwdata[dfpid_pkg::GAIN_W-1:0];
                end
                dfpid_pkg::REG_GAIN_I: begin
                    cfg_reg.gain_i <= pwdata[dfpid_pkg::GAIN_W-1:0];
                end
                dfpid_pkg::REG_GAIN_D: begin
                    cfg_reg.gain_d <= pwdata[dfpid_pkg::GAIN_W-1:0];
                end
                dfpid_pkg::REG_INTEGRAL_UPPER: begin
                    cfg_reg.integral_upper <= pwdata[dfpid_pkg::INTEG_W-1:0];
                end
                dfpid_pkg::REG_INTEGRAL_LOWER: begin
                    cfg_reg.integral_lower <= pwdata[dfpid_pkg::INTEG_W-1:0];
                end
                dfpid_pkg::REG_DRIVE_UPPER: begin
                    cfg_reg.drive_upper <= pwdata[dfpid_pkg::DRIVE_W-1:0];
                end
                dfpid_pkg::REG_DRIVE_LOWER: begin
                    cfg_reg.drive_lower <= pwdata[dfpid_pkg::DRIVE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Signed registers read back sign-extended.
    always_comb begin
        case (index)
            dfpid_pkg::REG_FORM_SELECT:    prdata = dfpid_pkg::DATA_W'(cfg_reg.form_select);
            dfpid_pkg::REG_GAIN_P:         prdata = dfpid_pkg::DATA_W'(cfg_reg.gain_p);
            dfpid_pkg::REG_GAIN_I:         prdata = dfpid_pkg::DATA_W'(cfg_reg.gain_i);
            dfpid_pkg::REG_GAIN_D:         prdata = dfpid_pkg::DATA_W'(cfg_reg.gain_d);
            dfpid_pkg::REG_INTEGRAL_UPPER: prdata = dfpid_pkg::DATA_W'(cfg_reg.integral_upper);
            dfpid_pkg::REG_INTEGRAL_LOWER: prdata = dfpid_pkg::DATA_W'(cfg_reg.integral_lower);
            dfpid_pkg::REG_DRIVE_UPPER:    prdata = dfpid_pkg::DATA_W'(cfg_reg.drive_upper);
            dfpid_pkg::REG_DRIVE_LOWER:    prdata = dfpid_pkg::DATA_W'(cfg_reg.drive_lower);
            default:                       prdata = '0;
        endcase
    end

endmodule

// ===== rtl/dfpid_calc.sv =====
// Combinational control law of the dual-form PID controller: error, clamps, products, drive.
module dfpid_calc (
    input  dfpid_pkg::cfg_t                             cfg,
    input  dfpid_pkg::pid_state_t                       state,
    input  logic signed [dfpid_pkg::SAMPLE_WIDTH-1:0]   measured,
    input  logic signed [dfpid_pkg::SAMPLE_WIDTH-1:0]   setpoint,
    input  logic                                        clear,
    output dfpid_pkg::pid_state_t                       state_next,
    output logic signed [dfpid_pkg::DRIVE_W-1:0]        drive,
    output logic                                        limited
);

    localparam int ERR_W   = dfpid_pkg::ERR_W;
    localparam int DIFF1_W = dfpid_pkg::DIFF1_W;
    localparam int DIFF2_W = dfpid_pkg::DIFF2_W;
    localparam int OPB_W   = dfpid_pkg::OPB_W;
    localparam int SUM_W   = dfpid_pkg::SUM_W;
    localparam int ACC_W   = dfpid_pkg::ACC_W;
    localparam int V_W     = dfpid_pkg::V_W;
    localparam int INTEG_W = dfpid_pkg::INTEG_W;
    localparam int TOTAL_W = dfpid_pkg::TOTAL_W;
    localparam int DRIVE_W = dfpid_pkg::DRIVE_W;

    localparam logic signed [ACC_W-1:0] TOTAL_MAX = ACC_W'({1'b0, {(TOTAL_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] TOTAL_MIN = ~TOTAL_MAX;

    logic                              incr;
    logic signed [ERR_W-1:0]           err;
    logic signed [DIFF1_W-1:0]         diff1;
    logic signed [DIFF2_W-1:0]         diff2;
    logic signed [SUM_W-1:0]           integ_sum;
    logic signed [SUM_W-1:0]           integ_hi;
    logic signed [SUM_W-1:0]           integ_clamp;
    logic signed [INTEG_W-1:0]         integ_new;
    logic signed [DIFF1_W-1:0]         op_a;
    logic signed [OPB_W-1:0]           op_b;
    logic signed [DIFF2_W-1:0]         op_c;
    logic signed [dfpid_pkg::PROD_A_W-1:0] prod_a;
    logic signed [dfpid_pkg::PROD_B_W-1:0] prod_b;
    logic signed [dfpid_pkg::PROD_C_W-1:0] prod_c;
    logic signed [ACC_W-1:0]           acc_sum;
    logic signed [ACC_W-1:0]           acc_inc;
    logic signed [TOTAL_W-1:0]         total_sat;
    logic signed [ACC_W-1:0]           acc;
    logic signed [V_W-1:0]             value;
    logic signed [V_W-1:0]             value_hi;
    logic signed [V_W-1:0]             value_clamp;

    assign incr = (cfg.form_select == dfpid_pkg::FORM_INCREMENTAL);

    assign err   = ERR_W'(measured) - ERR_W'(setpoint);
    assign diff1 = DIFF1_W'(err) - DIFF1_W'(state.last_error);
    assign diff2 = DIFF2_W'(err) - (DIFF2_W'(state.last_error) <<< 1)
                 + DIFF2_W'(state.older_error);

    // Integral clamp: the upper bound is applied first, so the lower one wins
    // when the bounds are inverted.
    assign integ_sum   = SUM_W'(state.integral) + SUM_W'(err);
    assign integ_hi    = (integ_sum >= SUM_W'(cfg.integral_upper)) ?
                         SUM_W'(cfg.integral_upper) : integ_sum;
    assign integ_clamp = (integ_hi <= SUM_W'(cfg.integral_lower)) ?
                         SUM_W'(cfg.integral_lower) : integ_hi;
    assign integ_new   = INTEG_W'(integ_clamp);

    // Three multipliers shared by both forms; only the operands change.
    assign op_a = incr ? diff1 : DIFF1_W'(err);
    assign op_b = incr ? OPB_W'(err) : OPB_W'(integ_new);
    assign op_c = incr ? diff2 : DIFF2_W'(diff1);

    assign prod_a = cfg.gain_p * op_a;
    assign prod_b = cfg.gain_i * op_b;
    assign prod_c = cfg.gain_d * op_c;

    assign acc_sum = ACC_W'(prod_a) + ACC_W'(prod_b) + ACC_W'(prod_c);
    assign acc_inc = acc_sum + ACC_W'(state.total);

    always_comb begin
        if (acc_inc > TOTAL_MAX) begin
            total_sat = TOTAL_W'(TOTAL_MAX);
        end else if (acc_inc < TOTAL_MIN) begin
            total_sat = TOTAL_W'(TOTAL_MIN);
        end else begin
            total_sat = TOTAL_W'(acc_inc);
        end
    end

    assign acc = incr ? ACC_W'(total_sat) : acc_sum;

    // The arithmetic shift drops the fraction bits with rounding toward minus infinity.
    assign value       = V_W'(acc >>> dfpid_pkg::GAIN_FRAC_BITS);
    assign value_hi    = (value >= V_W'(cfg.drive_upper)) ? V_W'(cfg.drive_upper) : value;
    assign value_clamp = (value_hi <= V_W'(cfg.drive_lower)) ? V_W'(cfg.drive_lower) : value_hi;

    always_comb begin
        if (clear) begin
            state_next = '0;
            drive      = '0;
            limited    = 1'b0;
        end else begin
            state_next.last_error  = err;
            state_next.older_error = state.last_error;
            state_next.integral    = incr ? state.integral : integ_new;
            state_next.total       = incr ? total_sat : state.total;
            drive                  = DRIVE_W'(value_clamp);
            limited                = (value_clamp != value);
        end
    end

endmodule

// ===== rtl/dual_form_pid_controller.sv =====
// Top level of the dual-form PID controller: request stages, controller state and register bank.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_measured, s_setpoint, s_clear
//  m_       out        m_valid / m_ready    m_drive, m_limited
//  apb      in         psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// The block sustains one request per cycle while the result side is not stalled. A
// request is captured in the input register; then the whole control law (error,
// integral clamp, the three gain multipliers, accumulator saturation and drive clamp)
// runs in one pass and loads the result register once that register is free, and the
// result is offered from there. The controller state feeds back through that same
// single pass.
// Reset is synchronous and active low: it empties both stages, zeroes the error
// history, the integral and the accumulator, and loads the register reset values.
// While m_ready is low the result holds and the input register still takes one
// further request before s_ready falls.
module dual_form_pid_controller (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic signed [dfpid_pkg::SAMPLE_WIDTH-1:0]   s_measured,
    input  logic signed [dfpid_pkg::SAMPLE_WIDTH-1:0]   s_setpoint,
    input  logic                                        s_clear,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [dfpid_pkg::DRIVE_W-1:0]        m_drive,
    output logic                                        m_limited,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [dfpid_pkg::ADDR_W-1:0]                paddr,
    input  logic [dfpid_pkg::DATA_W-1:0]                pwdata,
    output logic [dfpid_pkg::DATA_W-1:0]                prdata,
    output logic                                        pready
);

    dfpid_pkg::cfg_t        cfg;
    dfpid_pkg::pid_state_t  state_reg;
    dfpid_pkg::pid_state_t  state_next;

    logic                                       in_valid_reg;
    logic                                       in_valid_next;
    logic signed [dfpid_pkg::SAMPLE_WIDTH-1:0]  measured_reg;
    logic signed [dfpid_pkg::SAMPLE_WIDTH-1:0]  setpoint_reg;
    logic                                       clear_reg;
    logic                                       out_valid_reg;
    logic                                       out_valid_next;
    logic signed [dfpid_pkg::DRIVE_W-1:0]       drive_reg;
    logic signed [dfpid_pkg::DRIVE_W-1:0]       drive_next;
    logic                                       limited_reg;
    logic                                       limited_next;

    logic advance;
    logic load;
    logic take;

    assign pready = 1'b1;

    dfpid_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    dfpid_calc u_calc (
        .cfg        (cfg),
        .state      (state_reg),
        .measured   (measured_reg),
        .setpoint   (setpoint_reg),
        .clear      (clear_reg),
        .state_next (state_next),
        .drive      (drive_next),
        .limited    (limited_next)
    );

    // The result register frees up when it is empty or its request is taken this
    // cycle; the input register frees up when it is empty or moves on.
    assign advance = !out_valid_reg || m_ready;
    assign load    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = load || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (load) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            measured_reg <= s_measured;
            setpoint_reg <= s_setpoint;
            clear_reg    <= s_clear;
        end
        if (load) begin
            drive_reg   <= drive_next;
            limited_reg <= limited_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_drive   = drive_reg;
    assign m_limited = limited_reg;

    // A clear request leaves zeroed history and a zero, unlimited result.
    property p_clear_zeroes;
        @(posedge aclk) disable iff (!aresetn)
        (load && clear_reg) |=> (state_reg == '0 && drive_reg == '0 && !limited_reg);
    endproperty
    a_clear_zeroes: assert property (p_clear_zeroes)
        else $error("clear request did not zero the controller state and result");

    // A limited result sits exactly on one of the drive limits.
    property p_limited_on_bound;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_limited) |-> (m_drive == cfg.drive_upper || m_drive == cfg.drive_lower);
    endproperty
    a_limited_on_bound: assert property (p_limited_on_bound)
        else $error("limited result is not on a drive limit");

    // Back-pressure only when both stages hold a request and the result is stalled.
    property p_ready_only_when_full;
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready);
    endproperty
    a_ready_only_when_full: assert property (p_ready_only_when_full)
        else $error("input stalled while a stage was free");

    // State changes only when a request passes through the control law.
    property p_state_holds;
        @(posedge aclk) disable iff (!aresetn)
        !load |=> $stable(state_reg);
    endproperty
    a_state_holds: assert property (p_state_holds)
        else $error("controller state changed without a request");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the dual-form PID controller: request/result stream and APB setup.
module testbench;

    localparam int SAMPLE_WIDTH   = dfpid_pkg::SAMPLE_WIDTH;
    localparam int GAIN_FRAC_BITS = dfpid_pkg::GAIN_FRAC_BITS;
    localparam int GAIN_W         = dfpid_pkg::GAIN_W;
    localparam int INTEG_W        = dfpid_pkg::INTEG_W;
    localparam int DRIVE_W        = dfpid_pkg::DRIVE_W;
    localparam int TOTAL_W        = dfpid_pkg::TOTAL_W;
    localparam int ERR_W          = dfpid_pkg::ERR_W;
    localparam int DATA_W         = dfpid_pkg::DATA_W;
    localparam int ADDR_W         = dfpid_pkg::ADDR_W;

    // Generous ceiling on the run.
    localparam int CYCLE_LIMIT = 200000;
    // Idle padding after the last result has been taken, before a register write.
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 7;
    localparam int REQUESTS_PER_PHASE = 100;
    localparam int IDLE_PERCENT = 27;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam longint TOTAL_MAX = 64'sd2147483647;
    localparam longint TOTAL_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      limited;
    } drive_result_t;

    typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

    // One line of the directed table: either a register write or a request. A request
    // marked known carries its result typed in; all others are checked against the
    // controller predictor below.
    typedef struct {
        row_kind_t                      kind;
        dfpid_pkg::reg_index_t          index;
        logic [DATA_W-1:0]              value;
        logic signed [SAMPLE_WIDTH-1:0] measured;
        logic signed [SAMPLE_WIDTH-1:0] setpoint;
        logic                           clear;
        bit                             known;
        drive_result_t                  result;
    } row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic signed [SAMPLE_WIDTH-1:0] s_measured;
    logic signed [SAMPLE_WIDTH-1:0] s_setpoint;
    logic                           s_clear;
    logic                           m_valid;
    logic                           m_ready;
    logic signed [DRIVE_W-1:0]      m_drive;
    logic                           m_limited;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ADDR_W-1:0]              paddr;
    logic [DATA_W-1:0]              pwdata;
    logic [DATA_W-1:0]              prdata;
    logic                           pready;

    // Predictor copy of the controller: its configuration and its history.
    dfpid_pkg::cfg_t       ctl_cfg;
    dfpid_pkg::pid_state_t ctl_state;

    drive_result_t expected_drives[$];
    row_t          stimulus_table[$];

    // steady_flow turns idling off on both sides; hold_off_request asks the receiver
    // for one long stall.
    bit steady_flow;
    bit hold_off_request;

    int cycle_count;
    int mismatches;
    int requests_sent;
    int clears_sent;
    int results_checked;
    int settings_used;

    dual_form_pid_controller i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_measured (s_measured),
        .s_setpoint (s_setpoint),
        .s_clear    (s_clear),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .m_limited  (m_limited),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        aclk = 1'b0;
    end

    always #1 aclk = ~aclk;

    // The run is bounded by a plain cycle counter.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_drives.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One control tick of the predictor. A clear wipes the history and yields zero.
    // Otherwise the error goes through either the clamped-integral positional law or
    // the saturating incremental accumulator, and the drive is the floor of the Q8
    // value, clamped first to the upper then to the lower limit.
    function automatic drive_result_t predict_drive(logic signed [SAMPLE_WIDTH-1:0] measured,
                                                    logic signed [SAMPLE_WIDTH-1:0] setpoint,
                                                    logic clear);
        longint err;
        longint last;
        longint older;
        longint kp;
        longint ki;
        longint kd;
        longint sum;
        longint acc;
        longint level;
        longint clamped;
        drive_result_t res;
        res = '0;
        if (clear) begin
            ctl_state = '0;
            return res;
        end
        kp    = $signed(ctl_cfg.gain_p);
        ki    = $signed(ctl_cfg.gain_i);
        kd    = $signed(ctl_cfg.gain_d);
        last  = $signed(ctl_state.last_error);
        older = $signed(ctl_state.older_error);
        err   = longint'(measured) - longint'(setpoint);
        if (ctl_cfg.form_select == dfpid_pkg::FORM_POSITIONAL) begin
            sum = longint'($signed(ctl_state.integral)) + err;
            if (sum >= longint'($signed(ctl_cfg.integral_upper)))
                sum = $signed(ctl_cfg.integral_upper);
            if (sum <= longint'($signed(ctl_cfg.integral_lower)))
                sum = $signed(ctl_cfg.integral_lower);
            ctl_state.integral = sum[INTEG_W-1:0];
            acc = kp * err + ki * sum + kd * (err - last);
        end else begin
            sum = longint'($signed(ctl_state.total)) + kp * (err - last) + ki * err
                + kd * (err - 2 * last + older);
            if (sum > TOTAL_MAX) sum = TOTAL_MAX;
            if (sum < TOTAL_MIN) sum = TOTAL_MIN;
            ctl_state.total = sum[TOTAL_W-1:0];
            acc = sum;
        end
        ctl_state.older_error = ctl_state.last_error;
        ctl_state.last_error  = err[ERR_W-1:0];
        // An arithmetic shift of a signed value rounds toward minus infinity.
        level   = acc >>> GAIN_FRAC_BITS;
        clamped = level;
        if (clamped >= longint'($signed(ctl_cfg.drive_upper))) clamped = $signed(ctl_cfg.drive_upper);
        if (clamped <= longint'($signed(ctl_cfg.drive_lower))) clamped = $signed(ctl_cfg.drive_lower);
        res.drive   = clamped[DRIVE_W-1:0];
        res.limited = (clamped != level);
        return res;
    endfunction

    function automatic void add_request(logic signed [SAMPLE_WIDTH-1:0] measured,
                                        logic signed [SAMPLE_WIDTH-1:0] setpoint,
                                        logic clear);
        row_t r;
        r          = '{kind: ROW_REQUEST, index: dfpid_pkg::REG_FORM_SELECT, default: '0};
        r.kind     = ROW_REQUEST;
        r.measured = measured;
        r.setpoint = setpoint;
        r.clear    = clear;
        stimulus_table.push_back(r);
    endfunction

    function automatic void add_known(logic signed [SAMPLE_WIDTH-1:0] measured,
                                      logic signed [SAMPLE_WIDTH-1:0] setpoint,
                                      logic clear, logic signed [DRIVE_W-1:0] drive,
                                      logic limited);
        row_t r;
        r          = '{kind: ROW_REQUEST, index: dfpid_pkg::REG_FORM_SELECT, default: '0};
        r.kind     = ROW_REQUEST;
        r.measured = measured;
        r.setpoint = setpoint;
        r.clear    = clear;
        r.known    = 1'b1;
        r.result   = '{drive: drive, limited: limited};
        stimulus_table.push_back(r);
    endfunction

    function automatic void add_write(dfpid_pkg::reg_index_t index, logic [DATA_W-1:0] value);
        row_t r;
        r       = '{kind: ROW_WRITE, index: dfpid_pkg::REG_FORM_SELECT, default: '0};
        r.kind  = ROW_WRITE;
        r.index = index;
        r.value = value;
        stimulus_table.push_back(r);
    endfunction

    // Sign-extended 32-bit images of signed register values.
    function automatic logic [DATA_W-1:0] word16(logic signed [15:0] v);
        return DATA_W'(v);
    endfunction

    function automatic logic [DATA_W-1:0] word24(logic signed [23:0] v);
        return DATA_W'(v);
    endfunction

    // Stop offering requests and wait until the block has delivered every result and
    // has had time to go quiet, so that a register write cannot hit a request in flight.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_drives.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value at the
    // rising edge that closes the access cycle. The predictor copy is updated alongside.
    task automatic write_register(dfpid_pkg::reg_index_t index, logic [DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            dfpid_pkg::REG_FORM_SELECT:    ctl_cfg.form_select    = value[0];
            dfpid_pkg::REG_GAIN_P:         ctl_cfg.gain_p         = value[GAIN_W-1:0];
            dfpid_pkg::REG_GAIN_I:         ctl_cfg.gain_i         = value[GAIN_W-1:0];
            dfpid_pkg::REG_GAIN_D:         ctl_cfg.gain_d         = value[GAIN_W-1:0];
            dfpid_pkg::REG_INTEGRAL_UPPER: ctl_cfg.integral_upper = value[INTEG_W-1:0];
            dfpid_pkg::REG_INTEGRAL_LOWER: ctl_cfg.integral_lower = value[INTEG_W-1:0];
            dfpid_pkg::REG_DRIVE_UPPER:    ctl_cfg.drive_upper    = value[DRIVE_W-1:0];
            dfpid_pkg::REG_DRIVE_LOWER:    ctl_cfg.drive_lower    = value[DRIVE_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one request, idling at random first, and hold it until accepted. The
    // expected result is worked out at the accepting edge, in acceptance order.
    task automatic send_request(row_t r);
        drive_result_t want;
        @(negedge aclk);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_measured <= r.measured;
        s_setpoint <= r.setpoint;
        s_clear    <= r.clear;
        do @(posedge aclk); while (!s_ready);
        want = predict_drive(r.measured, r.setpoint, r.clear);
        if (r.known) want = r.result;
        expected_drives.push_back(want);
        requests_sent++;
        if (r.clear) clears_sent++;
    endtask

    // Sample values: mostly small so that errors stay in the interesting range near
    // the limits, with full-range values and the two extremes mixed in.
    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1, 2, 3: return SAMPLE_WIDTH'($urandom);
            default: return SAMPLE_WIDTH'($signed($urandom_range(800)) - 400);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? word16(16'sh7fff) : word16(16'sh8000);
            1:       return word16(16'($urandom));
            default: return word16(16'($signed($urandom_range(1200)) - 600));
        endcase
    endfunction

    // A fresh setting of every register for one random phase: the given form, random gains and bounds.
    task automatic randomize_settings(logic form);
        logic signed [23:0] int_hi;
        logic signed [23:0] int_lo;
        logic signed [15:0] drv_hi;
        logic signed [15:0] drv_lo;
        case ($urandom_range(3))
            0: begin
                int_hi = 24'sh7fffff;
                int_lo = 24'sh800000;
            end
            1: begin
                // Any pair, so the bounds may well be inverted.
                int_hi = 24'($urandom);
                int_lo = 24'($urandom);
            end
            default: begin
                int_hi = 24'($urandom_range(5000));
                int_lo = -24'($urandom_range(5000));
            end
        endcase
        case ($urandom_range(3))
            0: begin
                drv_hi = 16'sh7fff;
                drv_lo = 16'sh8000;
            end
            1: begin
                drv_hi = 16'($urandom);
                drv_lo = 16'($urandom);
            end
            default: begin
                drv_hi = 16'($urandom_range(4000));
                drv_lo = -16'($urandom_range(4000));
            end
        endcase
        write_register(dfpid_pkg::REG_FORM_SELECT, DATA_W'(form));
        write_register(dfpid_pkg::REG_GAIN_P, pick_gain());
        write_register(dfpid_pkg::REG_GAIN_I, pick_gain());
        write_register(dfpid_pkg::REG_GAIN_D, pick_gain());
        write_register(dfpid_pkg::REG_INTEGRAL_UPPER, word24(int_hi));
        write_register(dfpid_pkg::REG_INTEGRAL_LOWER, word24(int_lo));
        write_register(dfpid_pkg::REG_DRIVE_UPPER, word16(drv_hi));
        write_register(dfpid_pkg::REG_DRIVE_LOWER, word16(drv_lo));
        settings_used++;
    endtask

    // Result side: m_ready changes at the falling edge, idling at random, except in the
    // steady stretch and during the one long hold-off that the stimulus asks for.
    initial begin : result_ready_driver
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left        = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Every accepted result is matched against the oldest expectation, field by field.
    always @(posedge aclk) begin : result_checker
        drive_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_drives.size() == 0) begin
                $display("%0t: result drive=%0d limited=%0b arrived with no request pending",
                         $time, m_drive, m_limited);
                mismatches++;
            end else begin
                want = expected_drives.pop_front();
                results_checked++;
                if (m_drive !== want.drive) begin
                    $display("%0t: drive mismatch: expected %0d, actual %0d",
                             $time, want.drive, m_drive);
                    mismatches++;
                end
                if (m_limited !== want.limited) begin
                    $display("%0t: limited mismatch: expected %0b, actual %0b",
                             $time, want.limited, m_limited);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        row_t r;
        int   phase;
        int   n;

        cycle_count      = 0;
        mismatches       = 0;
        requests_sent    = 0;
        clears_sent      = 0;
        results_checked  = 0;
        settings_used    = 1;
        steady_flow      = 1'b0;
        hold_off_request = 1'b0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_measured       = '0;
        s_setpoint       = '0;
        s_clear          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;

        ctl_state                = '0;
        ctl_cfg                  = '0;
        ctl_cfg.form_select      = dfpid_pkg::FORM_POSITIONAL;
        ctl_cfg.integral_upper   = dfpid_pkg::INTEGRAL_UPPER_RST;
        ctl_cfg.integral_lower   = dfpid_pkg::INTEGRAL_LOWER_RST;
        ctl_cfg.drive_upper      = dfpid_pkg::DRIVE_UPPER_RST;
        ctl_cfg.drive_lower      = dfpid_pkg::DRIVE_LOWER_RST;

        // Directed part. Right after reset all gains are zero, so every request
        // yields zero whatever the error, and a clear always yields zero.
        add_known(16'sh7fff, 16'sh8000, 1'b0, 16'sd0, 1'b0);
        add_known(16'sh8000, 16'sh7fff, 1'b0, 16'sd0, 1'b0);
        add_known(-16'sd1, -16'sd1, 1'b1, 16'sd0, 1'b0);

        // Unity proportional gain only: the drive equals the error, which probes the
        // clamp boundaries. Landing exactly on a limit does not count as limited.
        add_write(dfpid_pkg::REG_GAIN_P, word16(16'sh0100));
        add_request(16'sd3000, 16'sd0, 1'b0);
        add_request(16'sd3001, 16'sd0, 1'b0);
        add_request(-16'sd3000, 16'sd0, 1'b0);
        add_request(16'sd0, 16'sd3001, 1'b0);

        // Extreme integral and derivative gains; the integral runs into both bounds.
        add_write(dfpid_pkg::REG_GAIN_I, word16(16'sh7fff));
        add_write(dfpid_pkg::REG_GAIN_D, word16(16'sh8000));
        add_request(16'sd100, 16'sd0, 1'b0);
        add_request(16'sh7fff, 16'sh8000, 1'b0);
        add_request(16'sh8000, 16'sh7fff, 1'b0);
        add_request(16'sd0, 16'sd0, 1'b0);
        add_known(16'sh7fff, 16'sh7fff, 1'b1, 16'sd0, 1'b0);

        // Inverted bounds: the lower integral bound and the lower drive limit win.
        add_write(dfpid_pkg::REG_INTEGRAL_UPPER, word24(24'sh800000));
        add_write(dfpid_pkg::REG_INTEGRAL_LOWER, word24(24'sh7fffff));
        add_write(dfpid_pkg::REG_DRIVE_UPPER, word16(16'sh8000));
        add_write(dfpid_pkg::REG_DRIVE_LOWER, word16(16'sh7fff));
        add_request(16'sd5, 16'sd3, 1'b0);

        // Widest bounds, small integral gain: the integral builds up over ticks.
        add_write(dfpid_pkg::REG_INTEGRAL_UPPER, word24(24'sh7fffff));
        add_write(dfpid_pkg::REG_INTEGRAL_LOWER, word24(24'sh800000));
        add_write(dfpid_pkg::REG_DRIVE_UPPER, word16(16'sh7fff));
        add_write(dfpid_pkg::REG_DRIVE_LOWER, word16(16'sh8000));
        add_write(dfpid_pkg::REG_GAIN_I, word16(16'sh0001));
        add_request(16'sh7fff, 16'sh8000, 1'b0);
        add_request(16'sh7fff, 16'sh8000, 1'b0);

        // Incremental form at full positive gains: the accumulator saturates at the top
        // and winds up far beyond the drive limits, so reversing the error takes time.
        add_write(dfpid_pkg::REG_FORM_SELECT, DATA_W'(dfpid_pkg::FORM_INCREMENTAL));
        add_write(dfpid_pkg::REG_GAIN_P, word16(16'sh7fff));
        add_write(dfpid_pkg::REG_GAIN_I, word16(16'sh7fff));
        add_write(dfpid_pkg::REG_GAIN_D, word16(16'sh7fff));
        add_write(dfpid_pkg::REG_DRIVE_UPPER, word16(16'sd3000));
        add_write(dfpid_pkg::REG_DRIVE_LOWER, word16(-16'sd3000));
        add_request(16'sh7fff, 16'sh8000, 1'b0);
        add_request(16'sh7fff, 16'sh8000, 1'b0);
        add_request(16'sh7fff, 16'sh8000, 1'b0);
        add_request(16'sh8000, 16'sh7fff, 1'b0);
        add_known(16'sd0, 16'sd0, 1'b1, 16'sd0, 1'b0);
        add_request(16'sh8000, 16'sh7fff, 1'b0);

        // Most negative gains drive the accumulator to its bottom.
        add_write(dfpid_pkg::REG_GAIN_P, word16(16'sh8000));
        add_write(dfpid_pkg::REG_GAIN_I, word16(16'sh8000));
        add_write(dfpid_pkg::REG_GAIN_D, word16(16'sh8000));
        add_request(16'sh7fff, 16'sh8000, 1'b0);
        add_request(16'sh7fff, 16'sh8000, 1'b0);

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stimulus_table[i]) begin
            r = stimulus_table[i];
            if (r.kind == ROW_WRITE) begin
                settle();
                write_register(r.index, r.value);
                settings_used++;
            end else begin
                send_request(r);
            end
        end

        // Random phases alternate the two forms. One phase runs with no idling on
        // either side; in another the receiver stalls long enough for the block to
        // fill and push back on the request side.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            randomize_settings(phase[0]);
            steady_flow = (phase == 2);
            if (phase == 4) hold_off_request = 1'b1;
            for (n = 0; n < REQUESTS_PER_PHASE; n++) begin
                r          = '{kind: ROW_REQUEST, index: dfpid_pkg::REG_FORM_SELECT,
                               default: '0};
                r.kind     = ROW_REQUEST;
                r.measured = pick_sample();
                r.setpoint = pick_sample();
                r.clear    = ($urandom_range(99) < 3);
                send_request(r);
            end
        end
        steady_flow = 1'b0;

        settle();
        $display("Checked %0d results for %0d requests (%0d clears) across %0d settings,",
                 results_checked, requests_sent, clears_sent, settings_used);
        $display("both control forms, inverted and extreme bounds, and a long output stall.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches found.", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dfpid_pkg.sv
rtl/dfpid_regs.sv
rtl/dfpid_calc.sv
rtl/dual_form_pid_controller.sv
tb/testbench.sv
